// File: sv/moving_tap_fractional_delay_reader_assert.svh
// Assertion macros shared by the moving tap delay reader modules.
`ifndef MOVING_TAP_FRACTIONAL_DELAY_READER_ASSERT_SVH
`define MOVING_TAP_FRACTIONAL_DELAY_READER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTFD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving tap reader: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving tap reader: next-cycle check failed");

`endif

// File: sv/mtfd_pkg.sv
// Shared types and constants of the moving tap fractional delay reader.
`timescale 1ns / 1ps
`default_nettype none

package mtfd_pkg;

    // Field widths of one request and one result.
    localparam int SAMPLE_W = 24;
    localparam int INDEX_W  = 32;
    localparam int SLOT_W   = 5;
    localparam int LOC_W    = 30;
    localparam int LEN_W    = 13;
    localparam int STEP_W   = 32;

    // Packing of the slave-side tdata bus, lowest field first.
    localparam int VALUE_LSB = 0;
    localparam int INDEX_LSB = VALUE_LSB + SAMPLE_W;
    localparam int SLOT_LSB  = INDEX_LSB + INDEX_W;
    localparam int LOC_LSB   = SLOT_LSB + SLOT_W;
    localparam int LEN_LSB   = LOC_LSB + LOC_W;
    localparam int IN_DATA_W = ((LEN_LSB + LEN_W + 7) / 8) * 8;

    // Packing of the slave-side tuser bus.
    localparam int USER_FUNC_BIT  = 0;
    localparam int USER_START_BIT = 1;
    localparam int IN_USER_W      = 2;

    localparam int OUT_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

    // Request function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RD    = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Divider control and status.
    typedef struct packed {
        logic start;
        logic negate;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: sv/moving_tap_fractional_delay_reader.sv
// A write is stored as it is accepted; a read goes through ST_RD and ST_OUT to the output.
// tready is low while a read is in progress; a block-start read with slot history also
// waits in ST_DIV for the bit-serial step divider.
// One request is in flight at a time; the output register lets the next request in early.
// After reset a clearing pass zeroes every ring entry, with tready low.
`timescale 1ns / 1ps
`default_nettype none

`include "moving_tap_fractional_delay_reader_assert.svh"

module moving_tap_fractional_delay_reader #(
    parameter int RING_DEPTH    = 16384,
    parameter int TAP_SLOTS     = 26,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // sample_value, sample_index, tap_slot, delay_location, block_length
    input  wire logic [mtfd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func, block_start
    input  wire logic [mtfd_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // out_sample
    output logic [mtfd_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tlast
);
    import mtfd_pkg::*;

    // The ring depth must be a power of two (not checked here), so ring wrapping is a mask.
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int POS_W    = RING_AW + FRACTION_BITS;
    localparam int SLOT_AW  = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
    localparam int SLOT_XW  = SLOT_W + SLOT_AW;
    localparam int EXT_W    = (POS_W > LOC_W) ? POS_W : LOC_W;
    localparam int ADV_W    = (POS_W > STEP_W) ? POS_W : STEP_W;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = FRACTION_BITS + 1 + DIFF_W;
    localparam int MIX_W    = SAMPLE_W + 3;
    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRACTION_BITS;
    localparam logic signed [MIX_W-1:0] SAT_MAX = MIX_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [MIX_W-1:0] SAT_MIN = -MIX_W'(1 << (SAMPLE_W - 1));

    // Request fields.
    logic                         in_func;
    logic                         in_start;
    logic signed [SAMPLE_W-1:0]   in_value;
    logic [INDEX_W-1:0]           in_index;
    logic [SLOT_W-1:0]            in_slot;
    logic [LOC_W-1:0]             in_loc;
    logic [LEN_W-1:0]             in_len;

    assign in_func  = s_axis_tuser[USER_FUNC_BIT];
    assign in_start = s_axis_tuser[USER_START_BIT];
    assign in_value = signed'(s_axis_tdata[VALUE_LSB +: SAMPLE_W]);
    assign in_index = s_axis_tdata[INDEX_LSB +: INDEX_W];
    assign in_slot  = s_axis_tdata[SLOT_LSB +: SLOT_W];
    assign in_loc   = s_axis_tdata[LOC_LSB +: LOC_W];
    assign in_len   = s_axis_tdata[LEN_LSB +: LEN_W];

    // Sequencer and persistent state.
    state_t                       state_reg, state_next;
    logic [RING_AW-1:0]           clr_cnt_reg;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [LEN_W-1:0]             rem_reg, rem_next;
    logic [TAP_SLOTS-1:0]         known_reg;

    // Request being processed.
    logic                         start_reg;
    logic                         slot_ok_reg;
    logic [SLOT_AW-1:0]           slot_addr_reg;
    logic [LOC_W-1:0]             loc_reg;
    logic [LEN_W-1:0]             len_reg;
    logic [FRACTION_BITS-1:0]     frac_reg;
    logic [POS_W-1:0]             pos_item_reg;
    logic [STEP_W-1:0]            step_pend_reg;
    logic signed [SAMPLE_W-1:0]   a_hold_reg;
    logic signed [PROD_W-1:0]     prod_reg;

    // Output register.
    logic                         m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]          m_data_reg;
    logic                         m_last_reg;

    // Memories and their read registers.
    logic signed [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
    logic [LOC_W-1:0]             prev_mem [TAP_SLOTS];
    logic signed [SAMPLE_W-1:0]   ring_a_reg;
    logic signed [SAMPLE_W-1:0]   ring_b_reg;
    logic [LOC_W-1:0]             prev_rd_reg;

    logic                         s_acc;
    logic                         read_acc;
    logic [SLOT_XW-1:0]           slot_wide;
    logic                         slot_ok;
    logic [SLOT_AW-1:0]           slot_addr;
    logic [LEN_W-1:0]             len_fix;
    logic [EXT_W-1:0]             start_diff;
    logic [POS_W-1:0]             pos_sel;
    logic [RING_AW-1:0]           rd_addr_a;
    logic [RING_AW-1:0]           rd_addr_b;
    logic                         ring_we;
    logic [RING_AW-1:0]           ring_wa;
    logic signed [SAMPLE_W-1:0]   ring_wd;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign read_acc      = s_acc && (in_func == FUNC_READ);

    // Start position, tap slot check and read addresses for a read request.
    always_comb
    begin
        slot_wide  = SLOT_XW'(in_slot);
        slot_ok    = (slot_wide < SLOT_XW'(TAP_SLOTS));
        slot_addr  = slot_wide[SLOT_AW-1:0];
        len_fix    = (in_len == '0) ? LEN_W'(1) : in_len;
        start_diff = EXT_W'({in_index[RING_AW-1:0], {FRACTION_BITS{1'b0}}}) - EXT_W'(in_loc);
        pos_sel    = in_start ? start_diff[POS_W-1:0] : pos_reg;
        rd_addr_a  = pos_sel[POS_W-1:FRACTION_BITS];
        rd_addr_b  = rd_addr_a + RING_AW'(1);
    end

    // Ring write port: the clearing pass, then sample writes.
    always_comb
    begin
        ring_we = (state_reg == ST_CLEAR) || (s_acc && (in_func == FUNC_WRITE));
        ring_wa = (state_reg == ST_CLEAR) ? clr_cnt_reg : in_index[RING_AW-1:0];
        ring_wd = (state_reg == ST_CLEAR) ? '0 : in_value;
    end

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        if (read_acc)
        begin
            ring_a_reg <= ring_mem[rd_addr_a];
            ring_b_reg <= ring_mem[rd_addr_b];
        end
    end

    // Interpolation difference and fractional product.
    logic signed [DIFF_W-1:0]     nb_diff;
    logic signed [PROD_W-1:0]     prod_calc;

    always_comb
    begin
        nb_diff   = signed'({ring_b_reg[SAMPLE_W-1], ring_b_reg})
                  - signed'({ring_a_reg[SAMPLE_W-1], ring_a_reg});
        prod_calc = signed'({1'b0, frac_reg}) * nb_diff;
    end

    // Location change since the slot's previous block start.
    logic signed [LOC_W:0]        loc_delta;
    logic                         delta_neg;
    logic [LOC_W:0]               delta_abs;
    logic                         prev_we;
    div_req_t                     div_req;
    div_stat_t                    div_stat;
    logic signed [LOC_W:0]        div_quo;

    always_comb
    begin
        loc_delta      = signed'({1'b0, loc_reg}) - signed'({1'b0, prev_rd_reg});
        delta_neg      = loc_delta[LOC_W];
        delta_abs      = delta_neg ? unsigned'(-loc_delta) : unsigned'(loc_delta);
        prev_we        = (state_reg == ST_RD) && start_reg && slot_ok_reg;
        div_req.start  = prev_we && known_reg[slot_addr_reg];
        div_req.negate = delta_neg;
    end

    mtfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (delta_abs[LOC_W-1:0]),
        .divisor  (len_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Previous location store, read at acceptance and written back in the following cycle, in ST_RD.
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[slot_addr_reg] <= loc_reg;
        end
        if (read_acc && in_start && slot_ok)
        begin
            prev_rd_reg <= prev_mem[slot_addr];
        end
    end

    // Result: mix, saturate, count down the block and advance the position.
    logic signed [PROD_W-1:0]     prod_sh;
    logic signed [MIX_W-1:0]      mix;
    logic [SAMPLE_W-1:0]          mix_sat;
    logic [LEN_W-1:0]             rem_base;
    logic                         out_last;
    logic                         commit;
    logic [STEP_W-1:0]            step_use;
    logic [ADV_W-1:0]             pos_adv;

    always_comb
    begin
        prod_sh = prod_reg >>> FRACTION_BITS;
        mix     = MIX_W'(a_hold_reg) + MIX_W'(prod_sh);
        if (mix > SAT_MAX)
        begin
            mix_sat = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (mix < SAT_MIN)
        begin
            mix_sat = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            mix_sat = mix[SAMPLE_W-1:0];
        end

        commit   = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
        rem_base = start_reg ? len_reg : rem_reg;
        step_use = start_reg ? step_pend_reg : step_reg;
        pos_adv  = ADV_W'(pos_item_reg) + ADV_W'(signed'(step_use));

        out_last  = 1'b0;
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        step_next = step_reg;
        if (commit)
        begin
            if (rem_base != '0)
            begin
                rem_next = rem_base - LEN_W'(1);
                out_last = (rem_next == '0);
            end
            else
            begin
                rem_next = '0;
            end
            pos_next  = pos_adv[POS_W-1:0];
            step_next = step_use;
        end

        m_valid_next = m_valid_reg;
        if (commit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Latch the read request and the working values of its stages.
    always_ff @(posedge clk)
    begin
        if (read_acc)
        begin
            slot_ok_reg   <= slot_ok;
            slot_addr_reg <= slot_addr;
            loc_reg       <= in_loc;
            len_reg       <= len_fix;
            frac_reg      <= pos_sel[FRACTION_BITS-1:0];
            pos_item_reg  <= pos_sel;
        end
        if (state_reg == ST_RD)
        begin
            a_hold_reg <= ring_a_reg;
            prod_reg   <= prod_calc;
            if (start_reg)
            begin
                step_pend_reg <= STEP_ONE;
            end
        end
        if ((state_reg == ST_DIV) && div_stat.done)
        begin
            step_pend_reg <= STEP_ONE + STEP_W'(div_quo);
        end
        if (commit)
        begin
            m_data_reg <= mix_sat;
            m_last_reg <= out_last;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == RING_AW'(RING_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (read_acc)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = div_req.start ? ST_DIV : ST_OUT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pos_reg     <= '0;
            step_reg    <= STEP_ONE;
            rem_reg     <= '0;
            known_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            step_reg    <= step_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + RING_AW'(1);
            end
            if (read_acc)
            begin
                start_reg <= in_start;
            end
            if (prev_we)
            begin
                known_reg[slot_addr_reg] <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_data_reg);
    assign m_axis_tlast  = m_last_reg;

    `MTFD_ASSERT_NEXT(a_write_gives_no_result, s_acc && (in_func == FUNC_WRITE),
                      !$rose(m_valid_reg))
    `MTFD_ASSERT_IMP(a_last_ends_block, m_valid_reg && m_last_reg, rem_reg == '0)
    `MTFD_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_reg == ST_DIV)

endmodule

`default_nettype wire

// File: sv/mtfd_div.sv
// Bit-serial signed-by-unsigned divider for the per-block step.
`timescale 1ns / 1ps
`default_nettype none

`include "moving_tap_fractional_delay_reader_assert.svh"

module mtfd_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mtfd_pkg::div_req_t              req,
    input  wire logic [mtfd_pkg::LOC_W-1:0]      dividend,
    input  wire logic [mtfd_pkg::LEN_W-1:0]      divisor,
    output mtfd_pkg::div_stat_t                  stat,
    output logic signed [mtfd_pkg::LOC_W:0]      quotient
);
    import mtfd_pkg::*;

    localparam int CNT_W = $clog2(LOC_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [LOC_W-1:0]    quo_reg;
    logic [LEN_W-1:0]    dsr_reg;

    logic [LEN_W:0]      rem_shift;
    logic [LEN_W:0]      rem_sub;
    logic                rem_ge;
    logic [LEN_W-1:0]    rem_step;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[LOC_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        rem_ge    = (rem_shift >= {1'b0, dsr_reg});
        rem_step  = rem_ge ? rem_sub[LEN_W-1:0] : rem_shift[LEN_W-1:0];
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LOC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient shifts in where the dividend shifts out.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
            neg_reg <= req.negate;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[LOC_W-2:0], rem_ge};
        end
    end

    // Truncation toward zero: divide magnitudes, then restore the sign.
    assign quotient = neg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `MTFD_ASSERT_NEXT(a_start_makes_busy, req.start, stat.busy)
    `MTFD_ASSERT_IMP(a_done_not_busy, stat.done, !stat.busy)
    `MTFD_ASSERT_IMP(a_done_follows_busy, stat.done, $past(stat.busy))

endmodule

`default_nettype wire
